// File: sv/fbsb_pkg.sv
// ----------------------------------------------------------------------------
// fbsb_pkg
// Shared types, constants and decode/CRC functions for the 4b6b receiver.
// ----------------------------------------------------------------------------
package fbsb_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  // One result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  len;
    logic        match;
    logic [7:0]  num;
    logic        err;
    logic        last;
  } res_t;

  // Receiver state. Leftover input bits never exceed five, and at most one
  // nibble waits for its partner between words.
  typedef struct packed {
    logic [4:0]  ib;
    logic [2:0]  ibc;
    logic [3:0]  nb;
    logic        nb_full;
    logic        err;
    logic [7:0]  bc;
    logic [7:0]  crc;
    logic [7:0]  prev;
    logic [7:0]  pc;
  } rx_state_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  nib;
  } sym_t;

  localparam logic [7:0] CRC_POLY      = 8'h9B;
  localparam logic [7:0] MAX_LEN_RESET = 8'd250;
  localparam int         RES_DEPTH     = 4;
  localparam int         RES_CNT_W     = $clog2(RES_DEPTH + 1);

  // 4b6b code to nibble
  function automatic sym_t sym_decode(input logic [5:0] code);
    sym_t s;
    s.ok = 1'b1;
    case (code)
      6'h15: s.nib = 4'h0;
      6'h31: s.nib = 4'h1;
      6'h32: s.nib = 4'h2;
      6'h23: s.nib = 4'h3;
      6'h34: s.nib = 4'h4;
      6'h25: s.nib = 4'h5;
      6'h26: s.nib = 4'h6;
      6'h16: s.nib = 4'h7;
      6'h1A: s.nib = 4'h8;
      6'h19: s.nib = 4'h9;
      6'h2A: s.nib = 4'hA;
      6'h0B: s.nib = 4'hB;
      6'h2C: s.nib = 4'hC;
      6'h0D: s.nib = 4'hD;
      6'h0E: s.nib = 4'hE;
      6'h1C: s.nib = 4'hF;
      default: begin
        s.ok  = 1'b0;
        s.nib = 4'h0;
      end
    endcase
    return s;
  endfunction

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/fbsb_step.sv
// ----------------------------------------------------------------------------
// fbsb_step
// Per-word next-state and result logic: cut codes, pack nibbles, CRC, end.
// ----------------------------------------------------------------------------
module fbsb_step (
  input  fbsb_pkg::rx_state_t st,
  input  logic [7:0]          radio_byte,
  input  logic [7:0]          max_len,
  output fbsb_pkg::rx_state_t st_next,
  output logic [1:0]          n_res,
  output fbsb_pkg::res_t      res0,
  output fbsb_pkg::res_t      res1
);
  import fbsb_pkg::*;

  logic [12:0] wide;
  logic [3:0]  c0;
  logic [3:0]  c1;
  logic [5:0]  code1;
  logic [5:0]  code2;
  sym_t        s1;
  sym_t        s2;
  logic [3:0]  cnt;
  logic        stop;
  logic        err;
  logic [11:0] acc;
  logic [1:0]  an;
  logic [12:0] keep_mask;
  logic [4:0]  ib_new;
  logic        have_b;
  logic [7:0]  b;
  res_t        fin;

  // wide holds c0 meaningful bits, oldest at the top
  assign wide  = {st.ib, radio_byte};
  assign c0    = {1'b0, st.ibc} + 4'd8;
  assign c1    = c0 - 4'd6;
  assign code1 = 6'(wide >> (c0 - 4'd6));
  assign code2 = 6'(wide >> (c1 - 4'd6));
  assign s1    = sym_decode(code1);
  assign s2    = sym_decode(code2);

  always_comb begin
    cnt  = c1;
    err  = st.err;
    acc  = {8'd0, st.nb};
    an   = {1'b0, st.nb_full};
    stop = 1'b0;
    if (code1 != 6'd0) begin
      if (s1.ok) begin
        acc = {acc[7:0], s1.nib};
        an  = an + 2'd1;
      end else begin
        err  = 1'b1;
        cnt  = 4'd0;
        stop = 1'b1;
      end
    end
    if (!stop && c1 >= 4'd6) begin
      cnt = c1 - 4'd6;
      if (code2 != 6'd0) begin
        if (s2.ok) begin
          acc = {acc[7:0], s2.nib};
          an  = an + 2'd1;
        end else begin
          err = 1'b1;
          cnt = 4'd0;
        end
      end
    end
  end

  assign keep_mask = (13'd1 << cnt) - 13'd1;
  assign ib_new    = 5'(wide & keep_mask);
  assign have_b    = an[1];
  assign b         = an[0] ? acc[11:4] : acc[7:0];

  always_comb begin
    st_next = st;
    n_res   = 2'd0;
    res0    = '0;
    res1    = '0;
    fin     = '0;
    if (radio_byte == 8'd0) begin
      if (st.bc != 8'd0) begin
        res0.kind  = KIND_END;
        res0.len   = st.bc;
        res0.match = (st.crc == st.prev);
        res0.num   = st.pc;
        res0.err   = st.err;
        n_res      = 2'd1;
        st_next    = '0;
        st_next.pc = st.pc + 8'd1;
      end
    end else begin
      st_next.ib      = ib_new;
      st_next.ibc     = 3'(cnt);
      st_next.nb      = acc[3:0];
      st_next.nb_full = an[0];
      st_next.err     = err;
      if (have_b) begin
        if (st.bc != 8'd0) begin
          st_next.crc = crc8_update(st.crc, st.prev);
        end
        st_next.prev = b;
        st_next.bc   = st.bc + 8'd1;
        res0.kind    = KIND_DATA;
        res0.data    = b;
        res0.len     = st_next.bc;
        res0.num     = st.pc;
        res0.err     = err;
        n_res        = 2'd1;
        if (st_next.bc >= max_len) begin
          // length limit: report drop, keep bit registers and error flag
          res1.kind    = KIND_DROP;
          res1.len     = st_next.bc;
          res1.num     = st.pc;
          res1.err     = err;
          n_res        = 2'd2;
          st_next.bc   = 8'd0;
          st_next.crc  = 8'd0;
          st_next.prev = 8'd0;
        end
      end
      // bad code with data in hand closes the packet
      if (err && st_next.bc != 8'd0 && n_res != 2'd2) begin
        fin.kind  = KIND_END;
        fin.len   = st_next.bc;
        fin.match = (st_next.crc == st_next.prev);
        fin.num   = st.pc;
        fin.err   = 1'b1;
        if (n_res == 2'd0) begin
          res0 = fin;
        end else begin
          res1 = fin;
        end
        n_res      = n_res + 2'd1;
        st_next    = '0;
        st_next.pc = st.pc + 8'd1;
      end
    end
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

endmodule

// File: sv/fbsb_res_queue.sv
// ----------------------------------------------------------------------------
// fbsb_res_queue
// Shifting result queue; takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module fbsb_res_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     push_n,
  input  fbsb_pkg::res_t push0,
  input  fbsb_pkg::res_t push1,
  input  logic           pop,
  output fbsb_pkg::res_t head,
  output logic           not_empty,
  output logic           room
);
  import fbsb_pkg::*;

  res_t                 q      [RES_DEPTH];
  res_t                 q_next [RES_DEPTH];
  res_t                 sh     [RES_DEPTH];
  logic [RES_CNT_W-1:0] cnt;
  logic [RES_CNT_W-1:0] cnt_next;
  logic [RES_CNT_W-1:0] base;

  assign base      = cnt - RES_CNT_W'(pop);
  assign cnt_next  = base + RES_CNT_W'(push_n);
  assign head      = q[0];
  assign not_empty = (cnt != '0);
  // room for a worst-case pair of results
  assign room      = (cnt <= RES_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    for (int i = 0; i < RES_DEPTH - 1; i++) begin
      sh[i] = pop ? q[i + 1] : q[i];
    end
    sh[RES_DEPTH-1] = q[RES_DEPTH-1];
    for (int i = 0; i < RES_DEPTH; i++) begin
      q_next[i] = sh[i];
      if (RES_CNT_W'(i) == base && push_n != 2'd0) begin
        q_next[i] = push0;
      end
      if (RES_CNT_W'(i) == base + RES_CNT_W'(1) && push_n == 2'd2) begin
        q_next[i] = push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

// File: sv/fourb_sixb_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// fourb_sixb_packet_receiver_core - 4b6b packet receiver with CRC-8 check
// Path: a radio word is registered in the input register, then its results
// are written into the result queue, whose head drives the result port.
// Throughput: one radio word per cycle while the result queue has room; a
// word that yields two results is absorbed by the four-entry result queue.
// Reset: sync, active high; clears state, queue, limit back to 250.
// ----------------------------------------------------------------------------
module fourb_sixb_packet_receiver_core (
  input  logic       clk,
  input  logic       rst,
  // radio word channel
  input  logic       radio_valid,
  output logic       radio_stall,
  input  logic [7:0] radio_byte,
  // result word channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [7:0] packet_length,
  output logic       crc_match,
  output logic [7:0] packet_number,
  output logic       symbol_error,
  output logic       last_result,
  // length limit register
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);
  import fbsb_pkg::*;

  // Input register: holds one radio word until the queue has room for
  // the up-to-two results it can make.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       adv;
  logic       room;

  logic [7:0] max_len;

  rx_state_t  st;
  rx_state_t  st_next;
  logic [1:0] n_res;
  res_t       r0;
  res_t       r1;
  res_t       head;
  logic       pop;

  assign adv         = hold_valid && room;
  assign radio_stall = hold_valid && !room;
  assign pop         = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (radio_valid && !radio_stall) begin
      hold_valid <= 1'b1;
    end else if (adv) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (radio_valid && !radio_stall) begin
      hold_byte <= radio_byte;
    end
  end

  // Limit register; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_len <= cfg_data;
    end
  end

  // Decode step: all work for one word between hold register and queue
  fbsb_step u_step (
    .st         (st),
    .radio_byte (hold_byte),
    .max_len    (max_len),
    .st_next    (st_next),
    .n_res      (n_res),
    .res0       (r0),
    .res1       (r1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  fbsb_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (adv ? n_res : 2'd0),
    .push0     (r0),
    .push1     (r1),
    .pop       (pop),
    .head      (head),
    .not_empty (result_valid),
    .room      (room)
  );

  assign kind          = head.kind;
  assign data_byte     = head.data;
  assign packet_length = head.len;
  assign crc_match     = head.match;
  assign packet_number = head.num;
  assign symbol_error  = head.err;
  assign last_result   = head.last;

  // A pair of results always opens with a data word and closes on the second
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    adv && n_res == 2'd2 |-> r0.kind == KIND_DATA && !r0.last && r1.last)
    else $error("result pair out of order");

  // Packet end clears the packet and advances the packet number
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    adv && ((n_res == 2'd1 && r0.kind == KIND_END) ||
            (n_res == 2'd2 && r1.kind == KIND_END))
    |=> st.bc == 8'd0 && !st.err && st.pc == $past(st.pc) + 8'd1)
    else $error("packet end did not clear state");

  // An error with bytes held must have closed the packet
  a_err_no_bytes: assert property (@(posedge clk) disable iff (rst)
    !(st.err && st.bc != 8'd0))
    else $error("error flag left set with packet bytes");

endmodule

// File: dv/fourb_sixb_packet_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// fourb_sixb_packet_receiver_core_tb - self-checking bench for the receiver
// Feeds radio words (encoded packets, corrupted packets, raw noise) through
// the radio channel with random gaps, predicts every result word in a local
// model of the decoder and checks the result channel field by field. The
// length limit is rewritten between phases, covering zero, one, 255 and the
// reset value.
// ----------------------------------------------------------------------------
module fourb_sixb_packet_receiver_core_tb;
  import fbsb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving
  localparam int DRAIN_CYCLES   = 8;     // lets the pipe drain after the last word
  localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
  localparam int NUM_PHASES     = 8;

  // DUT inputs, known from time zero
  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       radio_valid  = 1'b0;
  logic [7:0] radio_byte   = 8'h00;
  logic       result_stall = 1'b0;
  logic       cfg_write    = 1'b0;
  logic [7:0] cfg_data     = 8'h00;

  // DUT outputs
  logic       radio_stall;
  logic       result_valid;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] packet_length;
  logic       crc_match;
  logic [7:0] packet_number;
  logic       symbol_error;
  logic       last_result;

  // Radio words waiting to be offered, and result words waiting to arrive
  logic [7:0] radio_backlog[$];
  res_t       predicted_results[$];
  res_t       step_results[$];

  // Decoder state as the bench sees it
  logic [15:0] in_bits         = '0;
  int          in_cnt          = 0;
  logic [11:0] nib_bits        = '0;
  int          nib_cnt         = 0;
  logic        sym_err         = 1'b0;
  logic [7:0]  bytes_in_packet = '0;
  logic [7:0]  pkt_crc         = '0;
  logic [7:0]  last_byte       = '0;
  logic [7:0]  pkt_number      = '0;
  logic [7:0]  length_limit    = MAX_LEN_RESET;

  // Bench control
  logic steady     = 1'b0;  // no idling on either side while set
  logic timed_out  = 1'b0;
  int   mismatches = 0;
  int   idle_cycles = 0;

  always #6 clk = ~clk;

  fourb_sixb_packet_receiver_core u_top (
    .clk           (clk),
    .rst           (rst),
    .radio_valid   (radio_valid),
    .radio_stall   (radio_stall),
    .radio_byte    (radio_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .data_byte     (data_byte),
    .packet_length (packet_length),
    .crc_match     (crc_match),
    .packet_number (packet_number),
    .symbol_error  (symbol_error),
    .last_result   (last_result),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Code helpers
  // --------------------------------------------------------------------------

  // 4b6b line code for each nibble
  function automatic logic [5:0] nibble_code(input int n);
    case (n)
      0:  return 6'h15;
      1:  return 6'h31;
      2:  return 6'h32;
      3:  return 6'h23;
      4:  return 6'h34;
      5:  return 6'h25;
      6:  return 6'h26;
      7:  return 6'h16;
      8:  return 6'h1A;
      9:  return 6'h19;
      10: return 6'h2A;
      11: return 6'h0B;
      12: return 6'h2C;
      13: return 6'h0D;
      14: return 6'h0E;
      default: return 6'h1C;
    endcase
  endfunction

  // -1 for a code outside the set
  function automatic int symbol_to_nibble(input logic [5:0] code);
    for (int i = 0; i < 16; i++) begin
      if (nibble_code(i) == code) return i;
    end
    return -1;
  endfunction

  // CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  task automatic add_result(input kind_t k, input logic [7:0] d, input logic [7:0] len,
                            input logic m);
    res_t r;
    r.kind  = k;
    r.data  = d;
    r.len   = len;
    r.match = m;
    r.num   = pkt_number;
    r.err   = sym_err;
    r.last  = 1'b0;
    step_results.push_back(r);
  endtask

  // End of packet: report it, then wipe everything but the packet counter
  task automatic close_packet();
    add_result(KIND_END, 8'h00, bytes_in_packet, pkt_crc == last_byte);
    pkt_number++;
    in_bits         = '0;
    in_cnt          = 0;
    nib_bits        = '0;
    nib_cnt         = 0;
    sym_err         = 1'b0;
    bytes_in_packet = '0;
    pkt_crc         = '0;
    last_byte       = '0;
  endtask

  // Results caused by one accepted radio word
  task automatic decode_radio_word(input logic [7:0] w);
    logic [5:0] code;
    logic [7:0] b;
    int         nib;
    res_t       r;
    step_results.delete();
    if (w == 8'h00) begin
      // zero word ends a packet only if it holds bytes
      if (bytes_in_packet != 0) close_packet();
    end else begin
      in_bits = {in_bits[7:0], w};
      in_cnt += 8;
      while (in_cnt >= 6) begin
        code = 6'(in_bits >> (in_cnt - 6));
        in_cnt -= 6;
        if (code != 6'd0) begin
          nib = symbol_to_nibble(code);
          if (nib < 0) begin
            // bad code: flag it and throw away what is left of this word
            sym_err = 1'b1;
            in_cnt  = 0;
            break;
          end
          nib_bits = {nib_bits[7:0], 4'(nib)};
          nib_cnt += 4;
        end
      end
      in_bits &= (16'd1 << in_cnt) - 16'd1;

      if (nib_cnt >= 8) begin
        b = 8'(nib_bits >> (nib_cnt - 8));
        nib_cnt -= 8;
        nib_bits &= (12'd1 << nib_cnt) - 12'd1;
        if (bytes_in_packet != 0) pkt_crc = crc8_step(pkt_crc, last_byte);
        last_byte = b;
        bytes_in_packet++;
        add_result(KIND_DATA, b, bytes_in_packet, 1'b0);
        if (bytes_in_packet >= length_limit) begin
          // dropped at the limit; bit registers and the error flag survive
          add_result(KIND_DROP, 8'h00, bytes_in_packet, 1'b0);
          bytes_in_packet = '0;
          pkt_crc         = '0;
          last_byte       = '0;
        end
      end

      if (sym_err && bytes_in_packet != 0 && step_results.size() < 2) close_packet();
    end

    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) predicted_results.push_back(step_results[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  // Encode a packet of nbytes bytes into radio words. With good_crc the last
  // byte is the CRC of the ones before it. With corrupt one symbol is
  // replaced by a code outside the set. Now and then a zero code is slipped
  // in, which the decoder must skip.
  task automatic queue_packet(input int nbytes, input bit good_crc, input bit corrupt,
                              input bit terminate);
    logic [7:0]  payload[$];
    logic [7:0]  acc_crc;
    logic [31:0] bits;
    logic [5:0]  code;
    int          cnt;
    int          bad_sym;
    int          nib;
    acc_crc = '0;
    bits    = '0;
    cnt     = 0;
    for (int i = 0; i < nbytes - 1; i++) begin
      payload.push_back(8'($urandom));
      acc_crc = crc8_step(acc_crc, payload[i]);
    end
    payload.push_back(good_crc ? acc_crc : 8'($urandom));
    bad_sym = corrupt ? int'($urandom_range(0, 2 * nbytes - 1)) : -1;

    for (int s = 0; s < 2 * nbytes; s++) begin
      nib  = (s % 2 == 0) ? payload[s / 2][7:4] : payload[s / 2][3:0];
      code = nibble_code(nib);
      if (s == bad_sym) begin
        do code = 6'($urandom); while (code == 6'd0 || symbol_to_nibble(code) >= 0);
      end
      if ($urandom_range(0, 39) == 0) begin
        bits = bits << 6;
        cnt += 6;
      end
      bits = (bits << 6) | code;
      cnt += 6;
      while (cnt >= 8) begin
        radio_backlog.push_back(8'(bits >> (cnt - 8)));
        cnt -= 8;
      end
    end
    if (cnt > 0) radio_backlog.push_back(8'(bits << (8 - cnt)));
    if (terminate) radio_backlog.push_back(8'h00);
  endtask

  // Mostly well-formed packets, the rest broken ones and raw noise
  task automatic queue_mixed(input int words);
    int goal;
    int pick;
    int len;
    goal = radio_backlog.size() + words;
    while (radio_backlog.size() < goal) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      if (pick < 65) begin
        queue_packet(len, $urandom_range(0, 3) != 0, 1'b0, 1'b1);
      end else if (pick < 80) begin
        queue_packet(len, 1'b1, 1'b1, $urandom_range(0, 1));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) radio_backlog.push_back(8'($urandom));
      end else begin
        // no end marker: the next packet runs on into this one
        queue_packet(len, 1'b1, 1'b0, 1'b0);
      end
    end
  endtask

  // Wait until every word is taken and every result has come back, then
  // let the pipe drain in case the last words made no result
  task automatic settle();
    @(negedge clk);
    while (radio_backlog.size() != 0 || radio_valid || predicted_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    length_limit = v;
  endtask

  // --------------------------------------------------------------------------
  // Radio side driver: offers the backlog with random gaps, holds a stalled
  // word, and predicts each word as it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      radio_valid <= 1'b0;
    end else begin
      if (radio_valid && !radio_stall) begin
        decode_radio_word(radio_byte);
      end
      if (!radio_valid || !radio_stall) begin
        if (radio_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
          radio_valid <= 1'b1;
          radio_byte  <= radio_backlog.pop_front();
        end else begin
          radio_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side monitor: checks each taken result word against the oldest
  // prediction and drives a random stall, with one long hold-off
  // --------------------------------------------------------------------------
  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    int   results_seen;
    int   hold_left;
    bit   hold_done;
    if (rst) begin
      result_stall <= 1'b0;
      results_seen = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $display("%0t: stray result word, expected none actual kind %0d data %0h len %0d",
                   $time, kind, data_byte, packet_length);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("kind", want.kind, kind);
          compare_field("data_byte", want.data, data_byte);
          compare_field("packet_length", want.len, packet_length);
          compare_field("crc_match", want.match, crc_match);
          compare_field("packet_number", want.num, packet_number);
          compare_field("symbol_error", want.err, symbol_error);
          compare_field("last_result", want.last, last_result);
        end
      end

      // Long hold-off once the stream is well under way and the radio side
      // is still pushing, so the result queue fills and backs up the input
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 400 && radio_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !steady && ($urandom_range(0, 99) < 20);
      end
    end
  end

  // Cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (rst || (radio_valid && !radio_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed words, then phases under different limits
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] phase_limit[NUM_PHASES];
    int         phase_words[NUM_PHASES];
    // zero and one drop every byte, 255 needs the long packet
    phase_limit = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 30)),
                    8'($urandom_range(2, 30)), MAX_LEN_RESET,
                    8'($urandom_range(2, 30)), 8'($urandom_range(1, 255))};
    phase_words = '{40, 120, 120, 150, 150, 150, 150, 150};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    fork
      begin
        @(negedge clk);
        // zero word on an empty packet: nothing comes out
        radio_backlog.push_back(8'h00);
        // one-byte packet holding 0x00; CRC of nothing is zero, so it matches
        radio_backlog.push_back(8'h55);
        radio_backlog.push_back(8'h50);
        radio_backlog.push_back(8'h00);
        // bad code with no data: flag survives an empty end marker, then
        // the next decoded byte closes the packet at once
        radio_backlog.push_back(8'hFF);
        radio_backlog.push_back(8'h00);
        radio_backlog.push_back(8'h55);
        radio_backlog.push_back(8'h50);
        // good CRC, bad CRC, bad code somewhere in the data
        queue_packet(3, 1'b1, 1'b0, 1'b1);
        queue_packet(2, 1'b0, 1'b0, 1'b1);
        queue_packet(3, 1'b1, 1'b1, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
          settle();
          write_limit(phase_limit[p]);
          @(negedge clk);
          steady = (p == 1);
          if (phase_limit[p] == 8'd255) queue_packet(256, 1'b1, 1'b0, 1'b1);
          queue_mixed(phase_words[p]);
        end
        settle();
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, predicted_results.size());
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (!timed_out && mismatches == 0 && predicted_results.size() == 0) begin
      $display("fourb_sixb_packet_receiver_core_tb: PASS");
    end else begin
      $display("fourb_sixb_packet_receiver_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/fbsb_pkg.sv
sv/fbsb_step.sv
sv/fbsb_res_queue.sv
sv/fourb_sixb_packet_receiver_core.sv
dv/fourb_sixb_packet_receiver_core_tb.sv
